[rtl/nsc_pkg.sv]
// Shared types, character codes and result codes for the NMEA sentence checker.
// No dependencies; imported by nsc_char_step and nmea_sentence_checker.
`default_nettype none

package nsc_pkg;

    // Parse phase of the line currently being received.
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_BODY,
        PH_HEXOK,
        PH_HEXBAD,
        PH_NODLR
    } t_phase;

    // Reject reasons.
    localparam logic [2:0] REASON_NONE     = 3'd0;
    localparam logic [2:0] REASON_NO_DLR   = 3'd1;
    localparam logic [2:0] REASON_SHORT    = 3'd2;
    localparam logic [2:0] REASON_BAD_HEX  = 3'd3;
    localparam logic [2:0] REASON_MISMATCH = 3'd4;

    // Sentence kinds.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_GSA   = 2'd2;
    localparam logic [1:0] KIND_ZDA   = 2'd3;

    // Character codes.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_NEL    = 8'h85;
    localparam logic [7:0] CHAR_NBSP   = 8'hA0;

    // Identifier patterns: GPGGA, GPGSA, GPZDA, one row per sentence kind.
    localparam int          ID_KINDS = 3;
    localparam logic [2:0]  ID_LEN     = 3'd5;
    localparam logic [2:0]  ID_POS_MAX = 3'd7;
    localparam logic [7:0]  ID_PATTERN [ID_KINDS][5] = '{
        '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
        '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
        '{8'h47, 8'h50, 8'h5A, 8'h44, 8'h41}
    };

    // Field numbers and limits.
    localparam logic [3:0] FIELD_GSA_MODE    = 4'd2;
    localparam logic [3:0] FIELD_GGA_QUALITY = 4'd6;
    localparam logic [3:0] FIELD_MAX         = 4'd15;
    localparam logic [7:0] NUM_MAX           = 8'd15;
    localparam logic [1:0] HEX_DIGITS        = 2'd2;
    localparam logic [3:0] FIX_MODE_3D       = 4'd3;

    // Per-line parser state.
    typedef struct packed {
        t_phase      phase;
        logic [7:0]  running_xor;
        logic [7:0]  hex_value;
        logic [1:0]  hex_count;
        logic [2:0]  id_position;
        logic [2:0]  id_match_flags;
        logic [3:0]  field_number;
        logic [3:0]  field_value;
        logic        non_digit;
        logic [3:0]  gsa_mode;
        logic [3:0]  gga_quality;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        phase:          PH_WAIT,
        running_xor:    8'd0,
        hex_value:      8'd0,
        hex_count:      2'd0,
        id_position:    3'd0,
        id_match_flags: 3'b111,
        field_number:   4'd0,
        field_value:    4'd0,
        non_digit:      1'b0,
        gsa_mode:       4'd0,
        gga_quality:    4'd0
    };

    // One result item.
    typedef struct packed {
        logic        line_valid;
        logic [2:0]  reject_reason;
        logic [1:0]  sentence_kind;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [3:0]  fix_mode_now;
        logic        fix_mode_changed;
        logic        position_report;
    } t_line_result;

endpackage

`default_nettype wire

[rtl/nsc_char_step.sv]
// Combinational per-character update of the NMEA parser state and end-of-line evaluation.
// Depends on nsc_pkg.
`default_nettype none

module nsc_char_step (
    input  nsc_pkg::t_line_state  i_state,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  logic [3:0]            i_fix_mode,
    output nsc_pkg::t_line_state  o_state,
    output logic [3:0]            o_fix_mode,
    output nsc_pkg::t_line_result o_result
);
    import nsc_pkg::*;

    function automatic logic is_space(input logic [7:0] c);
        return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE ||
               c == CHAR_NEL || c == CHAR_NBSP;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic t_line_state close_field(input t_line_state s);
        t_line_state r;
        logic [3:0]  v;
        r = s;
        v = s.non_digit ? 4'd0 : s.field_value;
        if (s.field_number == FIELD_GSA_MODE) r.gsa_mode = v;
        if (s.field_number == FIELD_GGA_QUALITY) r.gga_quality = v;
        return r;
    endfunction

    function automatic t_line_state track_field(input t_line_state s, input logic [7:0] c);
        t_line_state r;
        logic [7:0]  d;
        logic [7:0]  sum;
        r   = s;
        d   = c - CHAR_ZERO;
        sum = ({4'd0, s.field_value} << 3) + ({4'd0, s.field_value} << 1) + {4'd0, d[3:0]};
        if (c == CHAR_COMMA) begin
            r = close_field(s);
            if (s.field_number == 4'd0 && s.id_position != ID_LEN) r.id_match_flags = 3'b000;
            if (s.field_number < FIELD_MAX) r.field_number = s.field_number + 4'd1;
            r.field_value = 4'd0;
            r.non_digit   = 1'b0;
        end else if (is_digit(c)) begin
            r.field_value = (sum > NUM_MAX) ? NUM_MAX[3:0] : sum[3:0];
        end else begin
            r.non_digit = 1'b1;
        end
        return r;
    endfunction

    function automatic t_line_state track_id(input t_line_state s, input logic [7:0] c);
        t_line_state r;
        r = s;
        if (s.field_number == 4'd0 && c != CHAR_COMMA) begin
            if (s.id_position < ID_LEN) begin
                for (int k = 0; k < ID_KINDS; k++) begin
                    if (ID_PATTERN[k][s.id_position] != c) r.id_match_flags[k] = 1'b0;
                end
            end else begin
                r.id_match_flags = 3'b000;
            end
            if (s.id_position < ID_POS_MAX) r.id_position = s.id_position + 3'd1;
        end
        return r;
    endfunction

    t_line_state w_step;
    t_line_state w_closed;
    logic [3:0]  w_hex_digit;
    logic        w_hex_ok;
    logic [2:0]  w_reason;
    logic [1:0]  w_kind;
    logic        w_changed;
    logic        w_report;
    logic [3:0]  w_fix_mode;

    // Hex digit decode of the incoming character.
    always_comb begin
        w_hex_ok    = 1'b1;
        w_hex_digit = 4'd0;
        if (is_digit(i_char)) begin
            w_hex_digit = i_char[3:0];
        end else if (i_char >= CHAR_LC_A && i_char <= CHAR_LC_F) begin
            w_hex_digit = i_char[3:0] + 4'd9;
        end else if (i_char >= CHAR_UC_A && i_char <= CHAR_UC_F) begin
            w_hex_digit = i_char[3:0] + 4'd9;
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    // Next state after this character.
    always_comb begin
        w_step = i_state;
        unique case (i_state.phase)
            PH_WAIT: begin
                if (i_char == CHAR_DOLLAR) w_step.phase = PH_BODY;
                else if (!is_space(i_char)) w_step.phase = PH_NODLR;
            end
            PH_BODY: begin
                w_step = track_field(track_id(i_state, i_char), i_char);
                if (i_char == CHAR_STAR) w_step.phase = PH_HEXOK;
                else w_step.running_xor = i_state.running_xor ^ i_char;
            end
            PH_HEXOK, PH_HEXBAD: begin
                w_step = track_field(i_state, i_char);
                if (i_state.hex_count < HEX_DIGITS) begin
                    if (!w_hex_ok) w_step.phase = PH_HEXBAD;
                    w_step.hex_value = {i_state.hex_value[3:0],
                                        w_hex_ok ? w_hex_digit : 4'd0};
                    w_step.hex_count = i_state.hex_count + 2'd1;
                end
            end
            PH_NODLR: begin
            end
            default: begin
            end
        endcase
    end

    // End-of-line evaluation.
    always_comb begin
        w_closed = w_step;
        if (w_step.phase == PH_BODY || w_step.phase == PH_HEXOK || w_step.phase == PH_HEXBAD)
            w_closed = close_field(w_step);

        if (w_closed.phase == PH_WAIT || w_closed.phase == PH_NODLR)
            w_reason = REASON_NO_DLR;
        else if (w_closed.phase == PH_BODY || w_closed.hex_count < HEX_DIGITS)
            w_reason = REASON_SHORT;
        else if (w_closed.phase == PH_HEXBAD)
            w_reason = REASON_BAD_HEX;
        else if (w_closed.running_xor != w_closed.hex_value)
            w_reason = REASON_MISMATCH;
        else
            w_reason = REASON_NONE;

        w_kind = KIND_OTHER;
        if (w_reason == REASON_NONE && w_closed.field_number != 4'd0) begin
            if (w_closed.id_match_flags[0])      w_kind = KIND_GGA;
            else if (w_closed.id_match_flags[1]) w_kind = KIND_GSA;
            else if (w_closed.id_match_flags[2]) w_kind = KIND_ZDA;
        end

        w_changed  = 1'b0;
        w_fix_mode = i_fix_mode;
        if (w_kind == KIND_GSA && w_closed.field_number >= FIELD_GSA_MODE &&
            w_closed.gsa_mode != i_fix_mode) begin
            w_fix_mode = w_closed.gsa_mode;
            w_changed  = 1'b1;
        end
        w_report = (w_kind == KIND_GGA) && (w_closed.field_number >= FIELD_GGA_QUALITY) &&
                   (w_closed.gga_quality != 4'd0) && (i_fix_mode == FIX_MODE_3D);
    end

    // Outputs: either keep the advanced state, or hand out a result and restart.
    always_comb begin
        o_result.line_valid       = (w_reason == REASON_NONE);
        o_result.reject_reason    = w_reason;
        o_result.sentence_kind    = w_kind;
        o_result.computed_sum     = w_closed.running_xor;
        o_result.received_sum     = w_closed.hex_value;
        o_result.fix_mode_now     = w_fix_mode;
        o_result.fix_mode_changed = w_changed;
        o_result.position_report  = w_report;
        if (i_last) begin
            o_state    = LINE_CLEAR;
            o_fix_mode = w_fix_mode;
        end else begin
            o_state    = w_step;
            o_fix_mode = i_fix_mode;
        end
    end

endmodule

`default_nettype wire

[rtl/nmea_sentence_checker.sv]
// A character accepted into the input register is evaluated in the next cycle unless it ends a
// line and the result register is full and stalled; the result loads when that end is parsed.
// One character per cycle while no line end is held up; the parser is a single registered pass.
// Reset (i_rst_n low, synchronous): the parser returns to waiting for a line start, the fix mode
// clears to zero, and both the input register and the result register become empty.
// Top level of the NMEA sentence checker; depends on nsc_pkg and nsc_char_step.
`default_nettype none

module nmea_sentence_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_line_end,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_line_valid,
    output logic [2:0]  o_reject_reason,
    output logic [1:0]  o_sentence_kind,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum,
    output logic [3:0]  o_fix_mode_now,
    output logic        o_fix_mode_changed,
    output logic        o_position_report
);
    import nsc_pkg::*;

    // Input register: one character waits here for its parsing cycle.
    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;

    // Parser state that spans characters, and the fix mode that spans lines.
    t_line_state  r_state;
    t_line_state  n_state;
    logic [3:0]   r_fix_mode;
    logic [3:0]   n_fix_mode;

    // Result register; it decouples the result channel from the character channel.
    logic         r_out_valid;
    t_line_result r_out;
    t_line_result n_out;

    logic         w_out_free;
    logic         w_process;
    logic         w_accept;
    logic         w_load;

    // The result slot is free when empty or when its transaction completes this cycle.
    assign w_out_free = !r_out_valid || !i_stall;

    // A character is parsed unless it ends a line and the result slot is still occupied.
    assign w_process = r_in_valid && (!r_in_last || w_out_free);
    assign w_load    = w_process && r_in_last;

    // Only a character blocked in the input register holds the upstream side.
    assign o_stall  = r_in_valid && !w_process;
    assign w_accept = i_valid && !o_stall;

    nsc_char_step u_step (
        .i_state    (r_state),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .i_fix_mode (r_fix_mode),
        .o_state    (n_state),
        .o_fix_mode (n_fix_mode),
        .o_result   (n_out)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_process) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input payload needs no reset; it is only read while r_in_valid is set.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_line_end;
        end
    end

    // Parser state advances once per parsed character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= LINE_CLEAR;
            r_fix_mode <= 4'd0;
        end else if (w_process) begin
            r_state    <= n_state;
            r_fix_mode <= n_fix_mode;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_line_valid       = r_out.line_valid;
    assign o_reject_reason    = r_out.reject_reason;
    assign o_sentence_kind    = r_out.sentence_kind;
    assign o_computed_sum     = r_out.computed_sum;
    assign o_received_sum     = r_out.received_sum;
    assign o_fix_mode_now     = r_out.fix_mode_now;
    assign o_fix_mode_changed = r_out.fix_mode_changed;
    assign o_position_report  = r_out.position_report;

    // A fix mode change only ever comes from a valid GSA sentence.
    a_change_from_gsa : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.fix_mode_changed |->
            r_out.line_valid && r_out.sentence_kind == KIND_GSA)
        else $error("fix mode change reported without a valid GSA sentence");

    // A position report needs a valid GGA sentence while in 3D fix.
    a_report_from_gga : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.position_report |->
            r_out.line_valid && r_out.sentence_kind == KIND_GGA &&
            r_out.fix_mode_now == FIX_MODE_3D)
        else $error("position report without a valid GGA sentence in 3D fix");

    // A rejected line carries a reason and no sentence kind.
    a_reject_consistent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_out.line_valid == (r_out.reject_reason == REASON_NONE)) &&
            (r_out.line_valid || r_out.sentence_kind == KIND_OTHER))
        else $error("reject reason and line validity disagree");

    // After a line ends, the parser is back at the start of a new line.
    a_line_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_state.phase == PH_WAIT && r_state.field_number == 4'd0 &&
                   r_state.running_xor == 8'd0)
        else $error("parser state not cleared after end of line");

endmodule

`default_nettype wire

[verif/tb_nmea_sentence_checker.sv]
// Self-checking testbench for nmea_sentence_checker: a character driver and a line-result
// monitor, with a behavioural parser that predicts every line result.
// Depends on nsc_pkg and the nmea_sentence_checker RTL.
`default_nettype none

module tb_nmea_sentence_checker;

    import nsc_pkg::*;

    // The run stops early with a failure if it ever gets this far.
    localparam int TIMEOUT_UNITS = 2_000_000;
    // After the last result, the run keeps going so that a stray result would still be seen.
    localparam int DRAIN_CYCLES  = 10;
    // Each side idles at random, roughly 17 percent of the time.
    localparam int IDLE_PERCENT  = 17;
    // A stretch of cycles in which neither side idles.
    localparam int QUIET_FROM    = 600;
    localparam int QUIET_TO      = 1100;
    // Once this many characters have gone in, the receiver stalls for a long stretch.
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 150;
    // Random stimulus stops once both of these have been queued.
    localparam int MIN_CHARS     = 1350;
    localparam int MIN_LINES     = 60;

    // The eight characters that count as whitespace ahead of the dollar sign.
    localparam logic [7:0] BLANK_CODES [8] = '{
        CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR, CHAR_SPACE, CHAR_NEL, CHAR_NBSP
    };

    // How a generated sentence ends after its payload.
    typedef enum {
        TAIL_GOOD,      // star and correct checksum in upper case
        TAIL_LOWER,     // star and correct checksum in lower case
        TAIL_WRONG,     // star and a well-formed but wrong checksum
        TAIL_BADHEX,    // star and a non-hex character in one of the two places
        TAIL_SHORT,     // star and fewer than two characters
        TAIL_NONE       // no star at all
    } t_tail;

    // One character waiting to be sent; pause holds it back until every line has reported.
    typedef struct {
        logic [7:0] code;
        logic       last;
        bit         pause;
    } t_char_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_line_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_line_valid;
    logic [2:0]  o_reject_reason;
    logic [1:0]  o_sentence_kind;
    logic [7:0]  o_computed_sum;
    logic [7:0]  o_received_sum;
    logic [3:0]  o_fix_mode_now;
    logic        o_fix_mode_changed;
    logic        o_position_report;

    nmea_sentence_checker u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_char_code        (i_char_code),
        .i_line_end         (i_line_end),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_line_valid       (o_line_valid),
        .o_reject_reason    (o_reject_reason),
        .o_sentence_kind    (o_sentence_kind),
        .o_computed_sum     (o_computed_sum),
        .o_received_sum     (o_received_sum),
        .o_fix_mode_now     (o_fix_mode_now),
        .o_fix_mode_changed (o_fix_mode_changed),
        .o_position_report  (o_position_report)
    );

    always #4 i_clk = ~i_clk;

    // Characters still to be sent, and line results still to arrive, oldest first.
    t_char_entry  char_queue [$];
    t_line_result expected_lines [$];

    // Shadow of the parser: the per-line state and the fix mode that survives between lines.
    t_line_state  line_st = LINE_CLEAR;
    logic [3:0]   fix_mode_model = 4'd0;

    // Line under construction by the stimulus tasks, and its running checksum.
    logic [7:0]   line_buf [$];
    logic [7:0]   payload_xor;
    int           lines_queued = 0;

    int           mismatches = 0;
    int           chars_accepted = 0;
    int           cycle_no = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    t_char_entry  next_char;
    t_line_result want;

    // ------------------------------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------------------------------

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE || c == CHAR_NEL ||
               c == CHAR_NBSP;
    endfunction

    // Value of a hex digit, or -1 for anything else.
    function automatic int hex_val(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
        if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
        if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return CHAR_ZERO + n;
        return (lower ? CHAR_LC_A : CHAR_UC_A) + n - 8'd10;
    endfunction

    // ------------------------------------------------------------------------------------------
    // Line parser prediction
    // ------------------------------------------------------------------------------------------

    // A field that held any non-digit reads as zero; only fields 2 and 6 are ever kept.
    task automatic close_field();
        logic [3:0] v;
        v = line_st.non_digit ? 4'd0 : line_st.field_value;
        if (line_st.field_number == FIELD_GSA_MODE)    line_st.gsa_mode = v;
        if (line_st.field_number == FIELD_GGA_QUALITY) line_st.gga_quality = v;
    endtask

    // Commas split fields over the whole line, the checksum tail included.
    task automatic track_field(input logic [7:0] c);
        int v;
        if (c == CHAR_COMMA) begin
            close_field();
            // An identifier of the wrong length cannot match any known sentence.
            if (line_st.field_number == 4'd0 && line_st.id_position != ID_LEN)
                line_st.id_match_flags = 3'b000;
            if (line_st.field_number < FIELD_MAX)
                line_st.field_number = line_st.field_number + 4'd1;
            line_st.field_value = 4'd0;
            line_st.non_digit   = 1'b0;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = int'(line_st.field_value) * 10 + int'(c - CHAR_ZERO);
            line_st.field_value = (v > int'(NUM_MAX)) ? 4'(NUM_MAX) : 4'(v);
        end else begin
            line_st.non_digit = 1'b1;
        end
    endtask

    // Each identifier character knocks out the patterns it does not agree with.
    task automatic track_id(input logic [7:0] c);
        if (line_st.field_number != 4'd0 || c == CHAR_COMMA) return;
        if (line_st.id_position < ID_LEN) begin
            for (int k = 0; k < ID_KINDS; k++)
                if (ID_PATTERN[k][line_st.id_position] != c)
                    line_st.id_match_flags[k] = 1'b0;
        end else begin
            line_st.id_match_flags = 3'b000;
        end
        if (line_st.id_position < ID_POS_MAX)
            line_st.id_position = line_st.id_position + 3'd1;
    endtask

    // Advances the shadow parser by one accepted character and, on the last character of a
    // line, queues the result that the line should produce.
    task automatic parse_char(input logic [7:0] c, input logic last);
        int           d;
        t_line_result r;
        case (line_st.phase)
            PH_WAIT: begin
                if (c == CHAR_DOLLAR)  line_st.phase = PH_BODY;
                else if (!is_blank(c)) line_st.phase = PH_NODLR;
            end
            PH_BODY: begin
                track_id(c);
                track_field(c);
                if (c == CHAR_STAR) line_st.phase = PH_HEXOK;
                else                line_st.running_xor ^= c;
            end
            PH_HEXOK, PH_HEXBAD: begin
                track_field(c);
                if (line_st.hex_count < HEX_DIGITS) begin
                    d = hex_val(c);
                    if (d < 0) begin
                        line_st.phase = PH_HEXBAD;
                        d = 0;
                    end
                    line_st.hex_value = {line_st.hex_value[3:0], 4'(d)};
                    line_st.hex_count = line_st.hex_count + 2'd1;
                end
            end
            default: ;
        endcase
        if (!last) return;

        if (line_st.phase == PH_BODY || line_st.phase == PH_HEXOK || line_st.phase == PH_HEXBAD)
            close_field();

        r = '0;
        if (line_st.phase == PH_WAIT || line_st.phase == PH_NODLR)
            r.reject_reason = REASON_NO_DLR;
        else if (line_st.phase == PH_BODY || line_st.hex_count < HEX_DIGITS)
            r.reject_reason = REASON_SHORT;
        else if (line_st.phase == PH_HEXBAD)
            r.reject_reason = REASON_BAD_HEX;
        else if (line_st.running_xor != line_st.hex_value)
            r.reject_reason = REASON_MISMATCH;
        else
            r.reject_reason = REASON_NONE;
        r.line_valid = (r.reject_reason == REASON_NONE);

        r.sentence_kind = KIND_OTHER;
        if (r.line_valid && line_st.field_number > 4'd0) begin
            if (line_st.id_match_flags[0])      r.sentence_kind = KIND_GGA;
            else if (line_st.id_match_flags[1]) r.sentence_kind = KIND_GSA;
            else if (line_st.id_match_flags[2]) r.sentence_kind = KIND_ZDA;
        end

        if (r.sentence_kind == KIND_GSA && line_st.field_number >= FIELD_GSA_MODE &&
            line_st.gsa_mode != fix_mode_model) begin
            fix_mode_model     = line_st.gsa_mode;
            r.fix_mode_changed = 1'b1;
        end
        // The report looks at the fix mode as it stands after this line.
        if (r.sentence_kind == KIND_GGA && line_st.field_number >= FIELD_GGA_QUALITY &&
            line_st.gga_quality > 4'd0 && fix_mode_model == FIX_MODE_3D)
            r.position_report = 1'b1;

        r.computed_sum = line_st.running_xor;
        r.received_sum = line_st.hex_value;
        r.fix_mode_now = fix_mode_model;
        expected_lines.push_back(r);
        line_st = LINE_CLEAR;
    endtask

    // ------------------------------------------------------------------------------------------
    // Sentence construction
    // ------------------------------------------------------------------------------------------

    task automatic add_raw_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic add_raw(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic add_payload_byte(input logic [7:0] b);
        line_buf.push_back(b);
        payload_xor ^= b;
    endtask

    task automatic add_payload(input string s);
        for (int i = 0; i < s.len(); i++) add_payload_byte(s[i]);
    endtask

    // Opens a sentence with some leading whitespace; eight blanks use every whitespace code.
    task automatic start_sentence(input int blanks);
        int offset;
        offset = $urandom_range(7);
        line_buf.delete();
        for (int i = 0; i < blanks; i++) line_buf.push_back(BLANK_CODES[(i + offset) % 8]);
        line_buf.push_back(CHAR_DOLLAR);
        payload_xor = 8'd0;
    endtask

    task automatic finish_sentence(input t_tail tail);
        logic [7:0] sum;
        logic [7:0] junk;
        int         n;
        if (tail == TAIL_NONE) return;
        line_buf.push_back(CHAR_STAR);
        sum = payload_xor;
        case (tail)
            TAIL_GOOD, TAIL_LOWER, TAIL_WRONG: begin
                if (tail == TAIL_WRONG) sum ^= 8'($urandom_range(255, 1));
                line_buf.push_back(hex_char(sum[7:4], tail == TAIL_LOWER));
                line_buf.push_back(hex_char(sum[3:0], tail == TAIL_LOWER));
            end
            TAIL_BADHEX: begin
                do junk = 8'($urandom); while (hex_val(junk) >= 0);
                if ($urandom_range(1)) begin
                    line_buf.push_back(junk);
                    line_buf.push_back(hex_char(sum[3:0], 1'b0));
                end else begin
                    line_buf.push_back(hex_char(sum[7:4], 1'b0));
                    line_buf.push_back(junk);
                end
            end
            default: begin
                n = $urandom_range(1);
                if (n == 1) line_buf.push_back(hex_char(sum[7:4], 1'b0));
            end
        endcase
    endtask

    // Hands the finished line to the driver; the last character carries the line end.
    task automatic queue_line(input bit pause);
        t_char_entry e;
        foreach (line_buf[i]) begin
            e.code  = line_buf[i];
            e.last  = (i == line_buf.size() - 1);
            e.pause = pause && (i == 0);
            char_queue.push_back(e);
        end
        line_buf.delete();
        lines_queued++;
    endtask

    // One comma and one field of random content; the GSA mode and the GGA quality lean
    // towards values that drive the fix mode to 3 and trigger position reports.
    task automatic add_field(input logic [1:0] hint, input int idx);
        int pick;
        int n;
        add_payload_byte(CHAR_COMMA);
        if (hint == KIND_GSA && idx == int'(FIELD_GSA_MODE) && $urandom_range(3) != 0) begin
            add_payload_byte(CHAR_ZERO + 8'($urandom_range(3, 1)));
        end else if (hint == KIND_GGA && idx == int'(FIELD_GGA_QUALITY) &&
                     $urandom_range(3) != 0) begin
            add_payload_byte(CHAR_ZERO + 8'($urandom_range(2)));
        end else begin
            pick = $urandom_range(99);
            n    = $urandom_range(3, 1);
            if (pick < 40) begin
                for (int i = 0; i < n; i++) add_payload_byte(CHAR_ZERO + 8'($urandom_range(9)));
            end else if (pick < 60) begin
                // Left empty.
            end else if (pick < 80) begin
                for (int i = 0; i < n; i++) add_payload_byte(CHAR_UC_A + 8'($urandom_range(25)));
            end else if (pick < 90) begin
                add_payload_byte(8'($urandom));
            end else begin
                add_payload("-");
                add_payload_byte(CHAR_ZERO + 8'($urandom_range(9)));
            end
        end
    endtask

    // A sentence with random identifier, fields and ending.
    task automatic random_sentence();
        string       id;
        logic [1:0]  hint;
        int          pick;
        int          n_fields;
        t_tail       tail;
        start_sentence(($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
        pick = $urandom_range(99);
        hint = KIND_OTHER;
        if (pick < 30) begin
            id = "GPGGA";
            hint = KIND_GGA;
        end else if (pick < 60) begin
            id = "GPGSA";
            hint = KIND_GSA;
        end else if (pick < 75) begin
            id = "GPZDA";
            hint = KIND_ZDA;
        end else if (pick < 90) begin
            // A near miss: one letter of a known identifier replaced.
            id = ($urandom_range(1) != 0) ? "GPGGA" : "GPZDA";
            id[$urandom_range(4)] = CHAR_UC_A + 8'($urandom_range(25));
        end else begin
            id = "";
            n_fields = $urandom_range(7, 1);
            for (int i = 0; i < n_fields; i++) id = {id, "A"};
            for (int i = 0; i < n_fields; i++) id[i] = CHAR_UC_A + 8'($urandom_range(25));
        end
        add_payload(id);

        n_fields = ($urandom_range(19) == 0) ? $urandom_range(18, 16) : $urandom_range(10);
        for (int i = 1; i <= n_fields; i++) add_field(hint, i);

        pick = $urandom_range(99);
        if (pick < 38)      tail = TAIL_GOOD;
        else if (pick < 75) tail = TAIL_LOWER;
        else if (pick < 83) tail = TAIL_WRONG;
        else if (pick < 89) tail = TAIL_BADHEX;
        else if (pick < 95) tail = TAIL_SHORT;
        else                tail = TAIL_NONE;
        finish_sentence(tail);
        // Commas after the checksum still open fields.
        if ($urandom_range(9) == 0) begin
            add_raw_byte(CHAR_COMMA);
            add_raw_byte(CHAR_ZERO + 8'($urandom_range(9)));
        end
        queue_line($urandom_range(99) < 8);
    endtask

    // A line of arbitrary bytes, mostly without a leading dollar sign.
    task automatic noise_line();
        int n;
        n = $urandom_range(12, 1);
        line_buf.delete();
        for (int i = 0; i < n; i++) add_raw_byte(8'($urandom));
        queue_line(1'b0);
    endtask

    // ------------------------------------------------------------------------------------------
    // Stimulus: directed lines first, then random ones
    // ------------------------------------------------------------------------------------------

    task automatic build_stimulus();
        // GSA with a mode of 3 and more fields than the counter can hold.
        start_sentence(0); add_payload("GPGSA,A,3,04,05,,,,,,,,,,1.8,1.0,1.5");
        finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // GGA with quality 1 while in 3D fix: a position report.
        start_sentence(0);
        add_payload("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,");
        finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // GGA with quality 0, lower-case checksum.
        start_sentence(0); add_payload("GPGGA,1,2,N,3,E,0,08");
        finish_sentence(TAIL_LOWER); queue_line(1'b0);
        start_sentence(0); add_payload("GPZDA,201530.00,04,07,2002,00,00");
        finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // An unknown identifier; the sender waits for every result before this one.
        start_sentence(0); add_payload("GPRMC,1,A");
        finish_sentence(TAIL_GOOD); queue_line(1'b1);
        // Identifier without a comma.
        start_sentence(0); add_payload("GPGGA");
        finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // Every whitespace code ahead of the dollar; the mode drops to 2.
        start_sentence(8); add_payload("GPGSA,A,2");
        finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // Blank lines.
        line_buf.delete(); add_raw_byte(CHAR_SPACE); add_raw_byte(CHAR_TAB); queue_line(1'b0);
        line_buf.delete(); add_raw_byte(CHAR_CR); queue_line(1'b0);
        // No dollar sign.
        line_buf.delete(); add_raw("GPGGA,1*00"); queue_line(1'b0);
        // No star, then a lone dollar sign.
        start_sentence(0); add_payload("GPGSA,A,3"); finish_sentence(TAIL_NONE); queue_line(1'b0);
        start_sentence(0); queue_line(1'b0);
        // Star with at most one digit, a non-hex digit, and a wrong checksum.
        start_sentence(0); add_payload("GPGSA,A,3"); finish_sentence(TAIL_SHORT);
        queue_line(1'b0);
        start_sentence(0); add_payload("GPZDA,1"); finish_sentence(TAIL_BADHEX); queue_line(1'b0);
        start_sentence(0); add_payload("GPGSA,A,3"); finish_sentence(TAIL_WRONG); queue_line(1'b0);
        // The mode field only appears after the checksum.
        start_sentence(0); add_payload("GPGSA,A"); finish_sentence(TAIL_GOOD);
        add_raw(",3"); queue_line(1'b0);
        // Saturating value, signed value, empty mode field, then back to 3.
        start_sentence(0); add_payload("GPGSA,A,99"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        start_sentence(0); add_payload("GPGSA,A,-3"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        start_sentence(0); add_payload("GPGSA,A,"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        start_sentence(0); add_payload("GPGSA,A,3"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // GSA too short to carry a mode, GGA too short to carry a quality.
        start_sentence(0); add_payload("GPGSA,A"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        start_sentence(0); add_payload("GPGGA,1,2,N,3,E"); finish_sentence(TAIL_GOOD);
        queue_line(1'b0);
        // Quality of two digits, with every earlier field empty.
        start_sentence(0); add_payload("GPGGA,,,,,,12"); finish_sentence(TAIL_GOOD);
        queue_line(1'b0);
        // Identifiers one character too long and too short.
        start_sentence(0); add_payload("GPGSAX,A,2"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        start_sentence(0); add_payload("GPGS,A,2"); finish_sentence(TAIL_GOOD); queue_line(1'b0);
        // Top-bit characters in the payload.
        start_sentence(0); add_payload("GPZDA,");
        add_payload_byte(8'hFF); add_payload_byte(8'h80); add_payload_byte(8'h7F);
        finish_sentence(TAIL_GOOD); queue_line(1'b0);

        while (char_queue.size() < MIN_CHARS || lines_queued < MIN_LINES) begin
            if ($urandom_range(99) < 12) noise_line();
            else                         random_sentence();
        end
    endtask

    // ------------------------------------------------------------------------------------------
    // Handshake sides
    // ------------------------------------------------------------------------------------------

    always @(posedge i_clk) cycle_no <= cycle_no + 1;

    // Random idling, switched off inside the quiet stretch.
    function automatic bit idle_now();
        if (cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // Character driver. A new transaction is offered only once the previous one has gone in,
    // so a stalled payload is never disturbed. A character marked for a pause is held back
    // until nothing is in flight and every line has reported.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (char_queue.size() != 0 && !idle_now() &&
                (!char_queue[0].pause || (!i_valid && expected_lines.size() == 0))) begin
                next_char   = char_queue.pop_front();
                i_valid     <= 1'b1;
                i_char_code <= next_char.code;
                i_line_end  <= next_char.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver. Once, after a couple of hundred characters, it stalls for a long
    // stretch while the driver keeps offering characters, so the block backs up and stalls
    // its own input; otherwise it stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && chars_accepted >= HOLD_AT) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= idle_now();
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Monitor. Results are checked before the shadow parser moves on, although a result can
    // never belong to a character accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_lines.size() == 0) begin
                    $error("result transaction with no line outstanding");
                    mismatches++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("line_valid", want.line_valid, o_line_valid);
                    check_field("reject_reason", want.reject_reason, o_reject_reason);
                    check_field("sentence_kind", want.sentence_kind, o_sentence_kind);
                    check_field("computed_sum", want.computed_sum, o_computed_sum);
                    check_field("received_sum", want.received_sum, o_received_sum);
                    check_field("fix_mode_now", want.fix_mode_now, o_fix_mode_now);
                    check_field("fix_mode_changed", want.fix_mode_changed, o_fix_mode_changed);
                    check_field("position_report", want.position_report, o_position_report);
                end
            end
            if (i_valid && !o_stall) begin
                chars_accepted++;
                parse_char(i_char_code, i_line_end);
            end
        end
    end

    // ------------------------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------------------------

    initial begin
        build_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait for every character to go in and every line to report.
        while (char_queue.size() != 0 || i_valid || expected_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("nmea_sentence_checker: match");
        end else begin
            $display("nmea_sentence_checker: mismatch");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("nmea_sentence_checker: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
